// File: design/assert_macros.svh
// Assertion helpers for the sorted key/value table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that a property holds at every rising clock edge outside reset.
`define SKVT_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define SKVT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define SKVT_ASSERT(label, clk, rst_n, prop, msg)
`define SKVT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// File: design/skvt_pkg.sv
`timescale 1ns / 1ps

package skvt_pkg;

	localparam int CAPACITY_DEF = 256;
	localparam int KEY_W        = 64;
	localparam int OWNER_W      = 64;
	localparam int COUNT_OUT_W  = 9;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_REMOVE = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_kind_t;

	typedef struct packed {
		req_kind_t            req_type;
		logic [KEY_W-1:0]     instance_key;
		logic [OWNER_W-1:0]   owner_value;
	} req_t;

	typedef struct packed {
		logic                   success;
		logic [OWNER_W-1:0]     found_owner;
		logic [COUNT_OUT_W-1:0] entries_in_use;
	} rsp_t;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [OWNER_W-1:0] owner;
	} entry_t;

endpackage

// File: design/skvt_ram.sv
`timescale 1ns / 1ps

module skvt_ram #(
	parameter int DEPTH  = skvt_pkg::CAPACITY_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic                clk,
	input  logic                re,
	input  logic [ADDR_W-1:0]   raddr,
	input  logic                we,
	input  logic [ADDR_W-1:0]   waddr,
	input  skvt_pkg::entry_t    wdata,
	output skvt_pkg::entry_t    rdata
);
	import skvt_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// File: design/skvt_seq.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module skvt_seq #(
	parameter int CAPACITY = skvt_pkg::CAPACITY_DEF,
	parameter int IDX_W    = $clog2(CAPACITY)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  skvt_pkg::req_t      req,
	output logic                done,
	output skvt_pkg::rsp_t      rsp,
	output logic                ram_re,
	output logic [IDX_W-1:0]    ram_raddr,
	output logic                ram_we,
	output logic [IDX_W-1:0]    ram_waddr,
	output skvt_pkg::entry_t    ram_wdata,
	input  skvt_pkg::entry_t    ram_rdata
);
	import skvt_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
	localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_SRCH  = 7'b0000010,
		S_CMP   = 7'b0000100,
		S_HIT   = 7'b0001000,
		S_EXEC  = 7'b0010000,
		S_MOVE  = 7'b0100000,
		S_FINAL = 7'b1000000
	} state_t;

	state_t                state_q;
	req_kind_t             op_q;
	logic [KEY_W-1:0]      key_q;
	logic [OWNER_W-1:0]    val_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      lo_q;
	logic [CNT_W-1:0]      hi_q;
	logic                  hit_q;
	logic [OWNER_W-1:0]    owner_q;
	logic [CNT_W-1:0]      src_q;
	logic [CNT_W-1:0]      left_q;
	logic                  mv_vld_s1;
	logic [IDX_W-1:0]      mv_dst_s1;
	logic                  done_q;
	rsp_t                  rsp_q;

	logic [CNT_W-1:0]      mid;
	logic [CNT_W-1:0]      src_inc;
	logic [CNT_W-1:0]      src_dec;
	logic                  is_ins;

	assign mid     = lo_q + ((hi_q - lo_q) >> 1);
	assign src_inc = src_q + ONE_C;
	assign src_dec = src_q - ONE_C;
	assign is_ins  = (op_q == REQ_INSERT);
	assign busy    = (state_q != S_IDLE);
	assign done    = done_q;
	assign rsp     = rsp_q;

	always_comb begin
		ram_re    = 1'b0;
		ram_raddr = mid[IDX_W-1:0];
		ram_we    = 1'b0;
		ram_waddr = mv_dst_s1;
		ram_wdata = ram_rdata;
		case (state_q)
			S_SRCH: begin
				if (lo_q < hi_q) begin
					ram_re = 1'b1;
				end else if (lo_q < cnt_q) begin
					ram_re    = 1'b1;
					ram_raddr = lo_q[IDX_W-1:0];
				end
			end
			S_MOVE: begin
				ram_re    = (left_q != '0);
				ram_raddr = src_q[IDX_W-1:0];
				ram_we    = mv_vld_s1;
			end
			S_FINAL: begin
				ram_we    = is_ins;
				ram_waddr = lo_q[IDX_W-1:0];
				ram_wdata = '{key: key_q, owner: val_q};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			mv_vld_s1 <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						op_q  <= req.req_type;
						key_q <= req.instance_key;
						val_q <= req.owner_value;
						lo_q  <= '0;
						hi_q  <= cnt_q;
						if (req.req_type == REQ_CLEAR) begin
							cnt_q  <= '0;
							done_q <= 1'b1;
							rsp_q  <= '{success: 1'b1, found_owner: '0, entries_in_use: '0};
						end else begin
							state_q <= S_SRCH;
						end
					end
				end
				S_SRCH: begin
					if (lo_q < hi_q) begin
						state_q <= S_CMP;
					end else if (lo_q < cnt_q) begin
						state_q <= S_HIT;
					end else begin
						hit_q   <= 1'b0;
						owner_q <= '0;
						state_q <= S_EXEC;
					end
				end
				S_CMP: begin
					if (ram_rdata.key < key_q) begin
						lo_q <= mid + ONE_C;
					end else begin
						hi_q <= mid;
					end
					state_q <= S_SRCH;
				end
				S_HIT: begin
					hit_q   <= (ram_rdata.key == key_q);
					owner_q <= ram_rdata.owner;
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					state_q <= S_IDLE;
					case (op_q)
						REQ_LOOKUP: begin
							done_q <= 1'b1;
							rsp_q.success        <= hit_q && (owner_q != '0);
							rsp_q.found_owner    <= hit_q ? owner_q : '0;
							rsp_q.entries_in_use <= COUNT_OUT_W'(cnt_q);
						end
						REQ_INSERT: begin
							if ((cnt_q < CAP_C) && !hit_q) begin
								src_q   <= cnt_q - ONE_C;
								left_q  <= cnt_q - lo_q;
								state_q <= S_MOVE;
							end else begin
								done_q <= 1'b1;
								rsp_q  <= '{success: 1'b0, found_owner: '0,
									entries_in_use: COUNT_OUT_W'(cnt_q)};
							end
						end
						REQ_REMOVE: begin
							if (hit_q) begin
								src_q   <= lo_q + ONE_C;
								left_q  <= cnt_q - lo_q - ONE_C;
								state_q <= S_MOVE;
							end else begin
								done_q <= 1'b1;
								rsp_q  <= '{success: 1'b0, found_owner: '0,
									entries_in_use: COUNT_OUT_W'(cnt_q)};
							end
						end
						default: begin
						end
					endcase
				end
				S_MOVE: begin
					if (left_q != '0) begin
						src_q     <= is_ins ? src_dec : src_inc;
						left_q    <= left_q - ONE_C;
						mv_vld_s1 <= 1'b1;
						mv_dst_s1 <= is_ins ? src_inc[IDX_W-1:0] : src_dec[IDX_W-1:0];
					end else begin
						mv_vld_s1 <= 1'b0;
						if (!mv_vld_s1) begin
							state_q <= S_FINAL;
						end
					end
				end
				S_FINAL: begin
					cnt_q   <= is_ins ? cnt_q + ONE_C : cnt_q - ONE_C;
					done_q  <= 1'b1;
					rsp_q   <= '{success: 1'b1, found_owner: '0,
						entries_in_use: COUNT_OUT_W'(is_ins ? cnt_q + ONE_C : cnt_q - ONE_C)};
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SKVT_NEVER(a_cnt_bound, clk, arst_n, cnt_q > CAP_C, "entry count above capacity")
	`SKVT_ASSERT(a_done_idle, clk, arst_n, done_q |-> (state_q == S_IDLE), "word sent while busy")
	`SKVT_NEVER(a_rw_clash, clk, arst_n, ram_re && ram_we && (ram_raddr == ram_waddr),
		"read and write of one entry in one cycle")
	`SKVT_ASSERT(a_move_drain, clk, arst_n, (state_q == S_FINAL) |-> !mv_vld_s1,
		"shift still in flight at final step")

endmodule

// File: design/sorted_key_value_table_core.sv
`timescale 1ns / 1ps
// Channel   Ports                 Handshake
// request   start, busy, req      word taken at a clock edge with start high, busy low
// response  done, rsp             word valid for the single cycle that done is high
//
// Clear answers in the cycle after it is taken and never raises busy.
// Lookup makes one memory read and one compare per search step, plus a read
// of the found entry.
// Insert and remove add the shift of the tail, one entry a cycle through the
// single read and single write port.
// Reset clears the entry count and the control state; the memory is never cleared.
// The receiver cannot stall; a new request is taken once busy is low.

module sorted_key_value_table_core #(
	parameter int CAPACITY = skvt_pkg::CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  skvt_pkg::req_t   req,
	output logic             done,
	output skvt_pkg::rsp_t   rsp
);
	import skvt_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);

	logic             ram_re;
	logic [IDX_W-1:0] ram_raddr;
	logic             ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t           ram_wdata;
	entry_t           ram_rdata;

	skvt_seq #(
		.CAPACITY (CAPACITY),
		.IDX_W    (IDX_W)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_rdata (ram_rdata)
	);

	skvt_ram #(
		.DEPTH  (CAPACITY),
		.ADDR_W (IDX_W)
	) u_ram (
		.clk   (clk),
		.re    (ram_re),
		.raddr (ram_raddr),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

endmodule

// File: tb/tb_sorted_key_value_table_core.sv
`timescale 1ns / 1ps

module tb_sorted_key_value_table_core;
	import skvt_pkg::*;

	localparam int DEPTH        = CAPACITY_DEF;
	localparam int IDLE_LIMIT   = 4000;
	localparam int DRAIN_CYCLES = 400;
	localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};
	localparam logic [KEY_W-1:0] KEY_MSB = {1'b1, {(KEY_W-1){1'b0}}};

	class table_scoreboard;
		logic [KEY_W-1:0]   keys [DEPTH];
		logic [OWNER_W-1:0] owners [DEPTH];
		int                 count;
		int                 errors;
		rsp_t               pending [$];

		function new();
			count  = 0;
			errors = 0;
		endfunction

		function int first_not_below(logic [KEY_W-1:0] k);
			int lo;
			int hi;
			int mid;
			lo = 0;
			hi = count;
			while (lo < hi) begin
				mid = (lo + hi) / 2;
				if (keys[mid] < k) begin
					lo = mid + 1;
				end else begin
					hi = mid;
				end
			end
			return lo;
		endfunction

		function void note_request(req_t w);
			int   pos;
			bit   hit;
			rsp_t r;
			pos = first_not_below(w.instance_key);
			hit = (pos < count) && (keys[pos] == w.instance_key);
			r   = '0;
			case (w.req_type)
				REQ_INSERT: begin
					if (count < DEPTH && !hit) begin
						for (int i = count; i > pos; i--) begin
							keys[i]   = keys[i-1];
							owners[i] = owners[i-1];
						end
						keys[pos]   = w.instance_key;
						owners[pos] = w.owner_value;
						count++;
						r.success = 1'b1;
					end
				end
				REQ_LOOKUP: begin
					if (hit && owners[pos] != '0) begin
						r.found_owner = owners[pos];
						r.success     = 1'b1;
					end
				end
				REQ_REMOVE: begin
					if (hit) begin
						for (int i = pos; i < count - 1; i++) begin
							keys[i]   = keys[i+1];
							owners[i] = owners[i+1];
						end
						count--;
						r.success = 1'b1;
					end
				end
				REQ_CLEAR: begin
					count     = 0;
					r.success = 1'b1;
				end
				default: begin
				end
			endcase
			r.entries_in_use = COUNT_OUT_W'(count);
			pending.push_back(r);
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				$error("response word with none expected: %h", got);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.success !== want.success) begin
				$error("success: expected %0d actual %0d", want.success, got.success);
				errors++;
			end
			if (got.found_owner !== want.found_owner) begin
				$error("found_owner: expected %h actual %h", want.found_owner,
					got.found_owner);
				errors++;
			end
			if (got.entries_in_use !== want.entries_in_use) begin
				$error("entries_in_use: expected %0d actual %0d", want.entries_in_use,
					got.entries_in_use);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic done;
	rsp_t rsp;

	table_scoreboard board;
	bit              no_gaps;
	int              idle_cycles;

	sorted_key_value_table_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && done) begin
			board.check_response(rsp);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb_sorted_key_value_table_core NOT OK");
				$finish;
			end
		end
	end

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [KEY_W-1:0] stored_key();
		return board.keys[$urandom_range(0, board.count - 1)];
	endfunction

	function automatic logic [KEY_W-1:0] pick_key();
		int sel;
		sel = $urandom_range(0, 9);
		if (board.count > 0 && sel <= 5) begin
			return stored_key();
		end
		if (board.count > 0 && sel == 6) begin
			return stored_key() + ($urandom_range(0, 1) ? KEY_W'(1) : KEY_MAX);
		end
		if (sel == 7) begin
			case ($urandom_range(0, 4))
				0: return '0;
				1: return KEY_MAX;
				2: return KEY_W'(1);
				3: return KEY_MSB;
				default: return KEY_MSB - KEY_W'(1);
			endcase
		end
		return rand64();
	endfunction

	function automatic logic [OWNER_W-1:0] pick_owner();
		return ($urandom_range(0, 9) == 0) ? '0 : rand64();
	endfunction

	task automatic send_word(req_kind_t kind, logic [KEY_W-1:0] k, logic [OWNER_W-1:0] v);
		int   gap;
		req_t w;
		w.req_type     = kind;
		w.instance_key = k;
		w.owner_value  = v;
		if ($urandom_range(0, 39) == 0) begin
			no_gaps = !no_gaps;
		end
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= w;
		do @(posedge clk); while (busy);
		board.note_request(w);
	endtask

	task automatic run_mixed(int n);
		int r;
		req_kind_t kind;
		repeat (n) begin
			r = $urandom_range(0, 199);
			if (r < 90) begin
				kind = REQ_INSERT;
			end else if (r < 150) begin
				kind = REQ_LOOKUP;
			end else if (r < 198) begin
				kind = REQ_REMOVE;
			end else begin
				kind = REQ_CLEAR;
			end
			send_word(kind, pick_key(), pick_owner());
		end
	endtask

	initial begin
		board       = new();
		no_gaps     = 1'b0;
		idle_cycles = 0;
		arst_n      = 1'b0;
		start       <= 1'b0;
		req         <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(REQ_LOOKUP, '0, rand64());
		send_word(REQ_REMOVE, KEY_MAX, rand64());
		send_word(REQ_INSERT, '0, {OWNER_W{1'b1}});
		send_word(REQ_INSERT, KEY_MAX, OWNER_W'(1));
		send_word(REQ_INSERT, KEY_MSB, '0);
		send_word(REQ_INSERT, '0, OWNER_W'(5));
		send_word(REQ_LOOKUP, '0, rand64());
		send_word(REQ_LOOKUP, KEY_MAX, rand64());
		send_word(REQ_LOOKUP, KEY_MSB, rand64());
		send_word(REQ_LOOKUP, KEY_W'(7), rand64());
		send_word(REQ_INSERT, KEY_MSB - KEY_W'(1), 64'hA5A5_A5A5_A5A5_A5A5);
		send_word(REQ_LOOKUP, KEY_MSB - KEY_W'(1), '0);
		send_word(REQ_REMOVE, KEY_MSB, rand64());
		send_word(REQ_LOOKUP, KEY_MSB, rand64());
		send_word(REQ_REMOVE, KEY_W'(12345), rand64());
		send_word(REQ_REMOVE, '0, rand64());
		send_word(REQ_REMOVE, KEY_MAX, rand64());
		send_word(REQ_CLEAR, rand64(), rand64());
		send_word(REQ_LOOKUP, KEY_MSB - KEY_W'(1), rand64());
		send_word(REQ_INSERT, KEY_W'(1), 64'h5A5A_5A5A_5A5A_5A5A);
		send_word(REQ_CLEAR, KEY_MAX, {OWNER_W{1'b1}});

		run_mixed(350);

		// insert past capacity, probe the table, then send a run of removes
		send_word(REQ_CLEAR, rand64(), rand64());
		repeat (DEPTH + 19) begin
			send_word(REQ_INSERT,
				(board.count > 0 && $urandom_range(0, 15) == 0) ? stored_key() : rand64(),
				pick_owner());
		end
		repeat (40) send_word(REQ_LOOKUP, pick_key(), rand64());
		repeat (DEPTH + 4) send_word(REQ_REMOVE, pick_key(), rand64());

		run_mixed(200);
		start <= 1'b0;

		while (board.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.errors == 0) begin
			$display("tb_sorted_key_value_table_core OK");
		end else begin
			$display("tb_sorted_key_value_table_core NOT OK");
		end
		$finish;
	end

endmodule

// File: sorted_key_value_table_core.f
+incdir+design
design/skvt_pkg.sv
design/skvt_ram.sv
design/skvt_seq.sv
design/sorted_key_value_table_core.sv
tb/tb_sorted_key_value_table_core.sv
